// ===== design/u8sd_pkg.sv =====
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared types, constants and helper functions of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8sd_pkg;

  localparam int unsigned RES_DEPTH = 4;

  localparam logic [7:0]  LEAD_MIN      = 8'hC0;
  localparam logic [31:0] CP_ASCII_END  = 32'h0000_0080;
  localparam logic [31:0] SURR_MASK     = 32'hFFFF_F800;
  localparam logic [31:0] SURR_BASE     = 32'h0000_D800;
  localparam logic [31:0] NONCHAR_MASK  = 32'hFFFF_FFFE;
  localparam logic [31:0] NONCHAR_BASE  = 32'h0000_FFFE;
  localparam logic [31:0] CP_REPLACE    = 32'h0000_FFFD;
  localparam logic [1:0]  UNITS_ONE     = 2'd1;
  localparam logic [1:0]  UNITS_TWO     = 2'd2;

  typedef struct packed {
    logic [31:0] code_point;
    logic [1:0]  utf16_units;
    logic        run_end;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } push_t;

  // Initial accumulator value for a lead byte, indexed by its low six bits
  function automatic logic [4:0] lead_init(input logic [5:0] idx);
    logic [4:0] v;
    if (idx < 6'd32) begin
      v = idx[4:0];
    end else if (idx < 6'd48) begin
      v = {1'b0, idx[3:0]};
    end else if (idx < 6'd56) begin
      v = {2'b00, idx[2:0]};
    end else if (idx < 6'd60) begin
      v = {3'b000, idx[1:0]};
    end else if (idx < 6'd62) begin
      v = {4'b0000, idx[0]};
    end else begin
      v = 5'd0;
    end
    return v;
  endfunction

  function automatic logic [31:0] finish_value(input logic [31:0] v);
    logic bad;
    bad = (v < CP_ASCII_END) || ((v & SURR_MASK) == SURR_BASE) ||
          ((v & NONCHAR_MASK) == NONCHAR_BASE);
    return bad ? CP_REPLACE : v;
  endfunction

  function automatic res_t make_res(input logic [31:0] cp, input logic last);
    res_t r;
    r.code_point  = cp;
    r.utf16_units = (cp[31:16] == 16'd0) ? UNITS_ONE : UNITS_TWO;
    r.run_end     = last;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/u8sd_in_if.sv =====
// ----------------------------------------------------------------------------
// u8sd_in_if
// Byte channel into the decoder: one raw byte and a last-byte flag per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

// ===== design/u8sd_out_if.sv =====
// ----------------------------------------------------------------------------
// u8sd_out_if
// Code point channel out of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8sd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_point;
  logic [1:0]  utf16_units;
  logic        run_end;

  modport source (output valid, output code_point, output utf16_units, output run_end,
                  input ready);
  modport sink   (input valid, input code_point, input utf16_units, input run_end,
                  output ready);
endinterface

`default_nettype wire

// ===== design/u8sd_decode.sv =====
// ----------------------------------------------------------------------------
// u8sd_decode
// Sequence state and per-byte decode; yields zero, one or two results.
// ----------------------------------------------------------------------------
`default_nettype none

module u8sd_decode (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          final_byte_i,
  output u8sd_pkg::push_t    push_o
);
  import u8sd_pkg::*;

  logic [31:0] acc_q, acc_d;
  logic        seq_q, seq_d;
  logic        is_cont, is_lead;
  logic [31:0] acc_shift, init_val, cp0, cp1, cp_new;
  logic        emit_new;
  logic [1:0]  n;

  assign is_cont   = (data_byte_i[7:6] == 2'b10);
  assign is_lead   = (data_byte_i >= LEAD_MIN);
  assign acc_shift = {acc_q[25:0], data_byte_i[5:0]};
  assign init_val  = {27'd0, lead_init(data_byte_i[5:0])};

  always_comb begin
    acc_d    = acc_q;
    seq_d    = seq_q;
    cp0      = '0;
    cp1      = '0;
    cp_new   = '0;
    emit_new = 1'b0;
    n        = 2'd0;
    if (seq_q && is_cont) begin
      acc_d = acc_shift;
      if (final_byte_i) begin
        cp0   = finish_value(acc_shift);
        n     = 2'd1;
        acc_d = '0;
        seq_d = 1'b0;
      end
    end else begin
      if (seq_q) begin
        cp0   = finish_value(acc_q);
        n     = 2'd1;
        acc_d = '0;
        seq_d = 1'b0;
      end
      if (is_lead) begin
        if (final_byte_i) begin
          cp_new   = finish_value(init_val);
          emit_new = 1'b1;
          acc_d    = '0;
          seq_d    = 1'b0;
        end else begin
          acc_d = init_val;
          seq_d = 1'b1;
        end
      end else begin
        cp_new   = {24'd0, data_byte_i};
        emit_new = 1'b1;
      end
      if (emit_new) begin
        if (n == 2'd1) begin
          cp1 = cp_new;
          n   = 2'd2;
        end else begin
          cp0 = cp_new;
          n   = 2'd1;
        end
      end
    end
  end

  assign push_o.count = accept_i ? n : 2'd0;
  assign push_o.res0  = make_res(cp0, n == 2'd1);
  assign push_o.res1  = make_res(cp1, 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      seq_q <= 1'b0;
    end else if (accept_i) begin
      acc_q <= acc_d;
      seq_q <= seq_d;
    end
  end

  // no sequence open implies an empty accumulator
  a_idle_acc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seq_q |-> (acc_q == '0))
    else $error("accumulator not clear outside a sequence");

  // a final byte always closes the sequence
  a_final_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && final_byte_i) |=> !seq_q)
    else $error("sequence still open after final byte");

  // two results only when an open sequence is closed by a non-continuation byte
  a_two_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count == 2'd2) |-> (seq_q && !is_cont))
    else $error("unexpected second result");

endmodule

`default_nettype wire

// ===== design/u8sd_res_fifo.sv =====
// ----------------------------------------------------------------------------
// u8sd_res_fifo
// Result queue; takes up to two results per cycle, sends one per cycle while ready.
// ----------------------------------------------------------------------------
`default_nettype none

module u8sd_res_fifo #(
  parameter int unsigned Depth = u8sd_pkg::RES_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  u8sd_pkg::push_t    push_i,
  output logic               room_o,
  u8sd_out_if.source         out_o
);
  import u8sd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr1;
  logic [CntW-1:0] count_q;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_ptr1 = ptr_inc(wr_ptr_q);
  assign pop     = out_o.valid && out_o.ready;
  assign room_o  = (count_q <= CntW'(Depth - 2));

  assign out_o.valid       = (count_q != '0);
  assign out_o.code_point  = mem[rd_ptr_q].code_point;
  assign out_o.utf16_units = mem[rd_ptr_q].utf16_units;
  assign out_o.run_end     = mem[rd_ptr_q].run_end;

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.count == 2'd2) begin
      mem[wr_ptr1] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i.count == 2'd1) begin
        wr_ptr_q <= wr_ptr1;
      end else if (push_i.count == 2'd2) begin
        wr_ptr_q <= ptr_inc(wr_ptr1);
      end
      if (pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      count_q <= count_q + CntW'(push_i.count) - CntW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result queue overflow");

  a_push_with_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> room_o)
    else $error("push without room");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == $past(count_q) + CntW'($past(push_i.count)) - CntW'($past(pop))))
    else $error("result count mismatch");

endmodule

`default_nettype wire

// ===== design/utf8_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// Lenient UTF-8 to UTF-32 decoder, one byte per item, with UTF-16 unit count.
//
//   channel  dir  payload                                  results per item
//   in_i     in   data_byte[7:0], final_byte                -
//   out_o    out  code_point[31:0], utf16_units[1:0],      0 to 2
//                 run_end
//
// One byte is accepted per cycle while the queue has room; its results are in
// the queue the next cycle. Input is taken while the result queue has room for
// two more results, as a byte that closes one sequence can yield a second.
// Rate is set by the output channel: one result per cycle while out_o is ready.
// Reset closes any open sequence, clears the accumulator and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder_top #(
  parameter int unsigned ResDepth = u8sd_pkg::RES_DEPTH
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  u8sd_in_if.sink     in_i,
  u8sd_out_if.source  out_o
);
  import u8sd_pkg::*;

  push_t push;
  logic  room;
  logic  accept;

  assign in_i.ready = room;
  assign accept     = in_i.valid && room;

  u8sd_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (in_i.data_byte),
    .final_byte_i (in_i.final_byte),
    .push_o       (push)
  );

  u8sd_res_fifo #(
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for utf8_stream_decoder_top. A directed table covers
// pass-through bytes, lead bytes flagged last, surrogate and noncharacter
// substitution, and sequences closed by a new byte. Random traffic follows:
// mostly well-formed UTF-8, mixed with stray, truncated and overlong runs.
// Every result is checked in order, against a row's fixed value or an in-bench model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  import u8sd_pkg::*;

  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned TAIL_CYCLES = 20;

  typedef struct {
    logic [7:0] data;
    logic       fin;
    logic       chk;
    res_t       fixed;
  } byte_item_t;

  logic clk_i;
  logic rst_ni;

  u8sd_in_if  in_if ();
  u8sd_out_if out_if ();

  utf8_stream_decoder_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // decoder model state
  logic [31:0] seq_acc  = '0;
  logic        seq_open = 1'b0;

  res_t        cp_exp_q[$];
  byte_item_t  cur_item;
  byte_item_t  seq_q[$];
  byte_item_t  dir_tab[];

  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int unsigned hold_req   = 0;
  int unsigned hold_ack   = 0;

  int unsigned n_err  = 0;
  int unsigned n_in   = 0;
  int unsigned n_out  = 0;
  int unsigned n_two  = 0;
  int unsigned n_repl = 0;
  int unsigned n_wide = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [4:0] lead_value(input logic [5:0] lo);
    casez (lo)
      6'b0?????: lead_value = lo[4:0];
      6'b10????: lead_value = {1'b0, lo[3:0]};
      6'b110???: lead_value = {2'b00, lo[2:0]};
      6'b1110??: lead_value = {3'b000, lo[1:0]};
      6'b11110?: lead_value = {4'b0000, lo[0]};
      default:   lead_value = 5'd0;
    endcase
  endfunction

  function automatic logic [31:0] fix_cp(input logic [31:0] v);
    if (v < 32'h80 || v[31:11] == 21'h1B || v[31:1] == 31'h7FFF) begin
      fix_cp = CP_REPLACE;
    end else begin
      fix_cp = v;
    end
  endfunction

  function automatic res_t to_res(input logic [31:0] cp);
    res_t r;
    r.code_point  = cp;
    r.utf16_units = (cp > 32'hFFFF) ? UNITS_TWO : UNITS_ONE;
    r.run_end     = 1'b0;
    return r;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic fin,
                             output int n, output res_t r[2]);
    bit absorbed;
    n        = 0;
    r[0]     = '0;
    r[1]     = '0;
    absorbed = 1'b0;
    if (seq_open) begin
      if (b[7:6] == 2'b10) begin
        absorbed = 1'b1;
        seq_acc  = (seq_acc << 6) + b[5:0];
        if (fin) begin
          r[n]     = to_res(fix_cp(seq_acc));
          n++;
          seq_acc  = '0;
          seq_open = 1'b0;
        end
      end else begin
        r[n]     = to_res(fix_cp(seq_acc));
        n++;
        seq_acc  = '0;
        seq_open = 1'b0;
      end
    end
    if (!absorbed) begin
      if (b >= LEAD_MIN) begin
        seq_acc = {27'd0, lead_value(b[5:0])};
        if (fin) begin
          r[n]    = to_res(fix_cp(seq_acc));
          n++;
          seq_acc = '0;
        end else begin
          seq_open = 1'b1;
        end
      end else begin
        r[n] = to_res({24'd0, b});
        n++;
      end
    end
    if (n > 0) r[n-1].run_end = 1'b1;
  endtask

  // input accept -> model, output accept -> compare
  always @(posedge clk_i) begin : mon
    int   n;
    res_t r[2];
    res_t e;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        decode_byte(in_if.data_byte, in_if.final_byte, n, r);
        n_in++;
        if (n == 2) n_two++;
        if (cur_item.chk) begin
          cp_exp_q = {cp_exp_q, cur_item.fixed};
        end else begin
          for (int i = 0; i < n; i++) cp_exp_q = {cp_exp_q, r[i]};
        end
      end
      if (out_if.valid && out_if.ready) begin
        n_out++;
        if (cp_exp_q.size() == 0) begin
          $error("unexpected result: code_point %h", out_if.code_point);
          n_err++;
        end else begin
          e = cp_exp_q.pop_front();
          if (e.code_point == CP_REPLACE) n_repl++;
          if (e.utf16_units == UNITS_TWO) n_wide++;
          if (out_if.code_point !== e.code_point) begin
            $error("code_point: expected %h, got %h", e.code_point, out_if.code_point);
            n_err++;
          end
          if (out_if.utf16_units !== e.utf16_units) begin
            $error("utf16_units: expected %0d, got %0d", e.utf16_units,
                   out_if.utf16_units);
            n_err++;
          end
          if (out_if.run_end !== e.run_end) begin
            $error("run_end: expected %0d, got %0d", e.run_end, out_if.run_end);
            n_err++;
          end
        end
      end
    end
  end

  // output side: random stalls, plus a long hold on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_ack) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_ack++;
      end
      out_if.ready <= !(rx_idle_en && ($urandom_range(99) < 21));
    end
  end

  function automatic byte_item_t row(input logic [7:0] b, input logic fin,
                                     input logic chk, input logic [31:0] cp);
    byte_item_t it;
    it.data  = b;
    it.fin   = fin;
    it.chk   = chk;
    it.fixed = '{code_point: cp, utf16_units: UNITS_ONE, run_end: 1'b1};
    return it;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input byte_item_t it);
    if (tx_idle_en) begin
      while ($urandom_range(99) < 21) begin
        in_if.valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    cur_item            <= it;
    in_if.valid         <= 1'b1;
    in_if.data_byte     <= it.data;
    in_if.final_byte    <= it.fin;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (cp_exp_q.size() != 0);
    @(negedge clk_i);
  endtask

  task automatic add_byte(input logic [7:0] b);
    seq_q = {seq_q, row(b, ($urandom_range(19) == 0), 1'b0, '0)};
  endtask

  task automatic build_sequence();
    int unsigned kind;
    int unsigned len;
    logic [31:0] cp;
    seq_q.delete();
    kind = $urandom_range(99);
    if (kind < 60) begin
      len = $urandom_range(1, 4);
      case (len)
        1: begin
          cp = $urandom_range(32'h7F);
          add_byte(cp[7:0]);
        end
        2: begin
          cp = $urandom_range(32'h80, 32'h7FF);
          add_byte({3'b110, cp[10:6]});
          add_byte({2'b10, cp[5:0]});
        end
        3: begin
          if ($urandom_range(9) == 0) begin
            case ($urandom_range(2))
              0:       cp = $urandom_range(32'hD800, 32'hDFFF);
              1:       cp = 32'hFFFE;
              default: cp = 32'hFFFF;
            endcase
          end else begin
            cp = $urandom_range(32'h800, 32'hFFFF);
          end
          add_byte({4'b1110, cp[15:12]});
          add_byte({2'b10, cp[11:6]});
          add_byte({2'b10, cp[5:0]});
        end
        default: begin
          cp = $urandom_range(32'h10000, 32'h1FFFFF);
          add_byte({5'b11110, cp[20:18]});
          add_byte({2'b10, cp[17:12]});
          add_byte({2'b10, cp[11:6]});
          add_byte({2'b10, cp[5:0]});
        end
      endcase
    end else if (kind < 70) begin
      len = $urandom_range(1, 3);
      repeat (len) add_byte({2'b10, 6'($urandom)});
    end else if (kind < 80) begin
      add_byte(8'($urandom_range(8'hC0, 8'hFF)));
      len = $urandom_range(0, 2);
      repeat (len) add_byte({2'b10, 6'($urandom)});
    end else if (kind < 90) begin
      // long runs can wrap the 32-bit accumulator
      add_byte(8'($urandom_range(8'hC0, 8'hFF)));
      len = $urandom_range(4, 9);
      repeat (len) add_byte({2'b10, 6'($urandom)});
    end else begin
      add_byte(8'($urandom_range(255)));
    end
    if ($urandom_range(5) == 0) seq_q[seq_q.size()-1].fin = 1'b1;
  endtask

  task automatic send_random(input int unsigned n_bytes);
    int unsigned cnt;
    cnt = 0;
    while (cnt < n_bytes) begin
      build_sequence();
      foreach (seq_q[k]) send_byte(seq_q[k]);
      cnt += seq_q.size();
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.data_byte   = '0;
    in_if.final_byte  = 1'b0;
    cur_item          = row(8'h00, 1'b0, 1'b0, '0);
    dir_tab = '{
      row(8'h00, 1'b0, 1'b1, 32'h00),
      row(8'h7F, 1'b0, 1'b1, 32'h7F),
      row(8'h80, 1'b0, 1'b1, 32'h80),
      row(8'hBF, 1'b1, 1'b1, 32'hBF),
      row(8'hC3, 1'b0, 1'b0, '0),
      row(8'hA9, 1'b0, 1'b0, '0),
      row(8'h41, 1'b0, 1'b0, '0),
      row(8'hE2, 1'b0, 1'b0, '0),
      row(8'h82, 1'b0, 1'b0, '0),
      row(8'hAC, 1'b1, 1'b0, '0),
      row(8'hF0, 1'b0, 1'b0, '0),
      row(8'h9F, 1'b0, 1'b0, '0),
      row(8'h98, 1'b0, 1'b0, '0),
      row(8'h80, 1'b1, 1'b0, '0),
      row(8'hC0, 1'b1, 1'b1, CP_REPLACE),
      row(8'hFF, 1'b1, 1'b1, CP_REPLACE),
      row(8'hED, 1'b0, 1'b0, '0),
      row(8'hA0, 1'b0, 1'b0, '0),
      row(8'h80, 1'b1, 1'b0, '0),
      row(8'hEF, 1'b0, 1'b0, '0),
      row(8'hBF, 1'b0, 1'b0, '0),
      row(8'hBF, 1'b0, 1'b0, '0),
      row(8'hC2, 1'b0, 1'b0, '0),
      row(8'hC2, 1'b0, 1'b0, '0),
      row(8'h41, 1'b1, 1'b0, '0)
    };
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[k]) send_byte(dir_tab[k]);
    wait_drained();

    send_random(200);
    wait_drained();

    // back to back, no random stalls on either side
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    send_random(120);

    // long output hold while input keeps offering
    rx_idle_en <= 1'b1;
    hold_req   <= hold_req + 1;
    send_random(80);
    wait_drained();

    tx_idle_en = 1'b1;
    send_random(100);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (cp_exp_q.size() != 0) begin
      $error("%0d results never arrived", cp_exp_q.size());
      n_err++;
    end
    $display("Run: %0d bytes in, %0d code points out, %0d bytes gave two results.",
             n_in, n_out, n_two);
    $display("Run: %0d replaced by U+FFFD, %0d needing two UTF-16 units.",
             n_repl, n_wide);
    if (n_err == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
